// ----- src/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes and control types for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int NUM_POOLS_DEF        = 4;
  localparam int ENTRIES_PER_POOL_DEF = 1024;

  localparam int WORD_BITS = 32;
  localparam int BIT_AW    = 5;
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 12;
  localparam int COUNT_W   = 13;
  localparam int STATUS_W  = 2;

  // pool_size is 13 bits, so no entry at or past 2**13 is ever usable
  localparam int MAX_WORDS       = (2 ** COUNT_W) / WORD_BITS;
  localparam int USE_WORDS_W     = $clog2(MAX_WORDS + 1);
  localparam int POOL_SIZE_RESET = 4096;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic capture;
    logic find;
    logic read;
    logic commit;
  } bsa_cmd_t;

  typedef struct packed {
    logic out_busy;
  } bsa_stat_t;

endpackage

// ----- src/bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Lowest-free-first slot allocator over a bitmap of used entries.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Allocate steps through a search of the
// word-full summary, a bitmap RAM read and the update, free through the RAM
// read and the update, and query goes straight to the update. The input is
// stalled until the update registers the result, and the update waits while
// the held result is stalled on out_stall. The single-port bitmap RAM sets these steps.
// A new request is taken while the previous result is still held. Reset and
// every pool_size write clear the bitmap and count at once; pool_size is
// clamped to the bitmap capacity.
module bitmap_slot_allocator #(
  parameter int NUM_POOLS        = bsa_pkg::NUM_POOLS_DEF,
  parameter int ENTRIES_PER_POOL = bsa_pkg::ENTRIES_PER_POOL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsa_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsa_pkg::OP_W-1:0]      operation,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsa_pkg::STATUS_W-1:0]  status,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_index,
  output logic [bsa_pkg::COUNT_W-1:0]   in_use
);

  bsa_pkg::bsa_cmd_t  cmd;
  bsa_pkg::bsa_stat_t stat;

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  bsa_datapath #(
    .NUM_POOLS        (NUM_POOLS),
    .ENTRIES_PER_POOL (ENTRIES_PER_POOL)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .slot_index    (slot_index),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_index (granted_index),
    .in_use        (in_use)
  );

endmodule

// ----- src/bsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer: steps one request through find (allocate only), bitmap read (allocate and free) and commit.
// ----------------------------------------------------------------------------
module bsa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [bsa_pkg::OP_W-1:0]  operation,
  input  bsa_pkg::bsa_stat_t        stat,
  output logic                      in_stall,
  output bsa_pkg::bsa_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_READ = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_stall    = (state != S_IDLE);
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.find    = (state == S_FIND);
    cmd.read    = (state == S_READ);
    cmd.commit  = (state == S_EXEC) && !stat.out_busy;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            bsa_pkg::OP_ALLOC: state_next = S_FIND;
            bsa_pkg::OP_FREE:  state_next = S_READ;
            default:           state_next = S_EXEC;
          endcase
        end
      end
      S_FIND: state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/bsa_datapath.sv -----
// ----------------------------------------------------------------------------
// bsa_datapath
// Bitmap RAM, word-full summary, free-word search, update logic and result
// register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
  parameter int NUM_POOLS        = bsa_pkg::NUM_POOLS_DEF,
  parameter int ENTRIES_PER_POOL = bsa_pkg::ENTRIES_PER_POOL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsa_pkg::COUNT_W-1:0]   cfg_data,
  input  logic [bsa_pkg::OP_W-1:0]      operation,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_index,
  input  bsa_pkg::bsa_cmd_t             cmd,
  output bsa_pkg::bsa_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsa_pkg::STATUS_W-1:0]  status,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_index,
  output logic [bsa_pkg::COUNT_W-1:0]   in_use
);

  localparam int CAPACITY  = NUM_POOLS * ENTRIES_PER_POOL;
  localparam int WORDS     = (CAPACITY + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
  localparam int EFF_WORDS = (WORDS < bsa_pkg::MAX_WORDS) ? WORDS : bsa_pkg::MAX_WORDS;
  localparam int WAW       = (EFF_WORDS > 1) ? $clog2(EFF_WORDS) : 1;
  localparam int CW        = bsa_pkg::COUNT_W;
  localparam int UW        = bsa_pkg::USE_WORDS_W;
  localparam int LIMIT_RST_I =
    (bsa_pkg::POOL_SIZE_RESET < CAPACITY) ? bsa_pkg::POOL_SIZE_RESET : CAPACITY;
  localparam logic [CW-1:0] LIMIT_RST = CW'(LIMIT_RST_I);
  localparam logic [UW-1:0] USE_WORDS_RST =
    UW'((LIMIT_RST_I + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS);

  logic [bsa_pkg::WORD_BITS-1:0] mem [EFF_WORDS];

  logic [EFF_WORDS-1:0]          wvalid;
  logic [EFF_WORDS-1:0]          full;
  logic [CW-1:0]                 limit;
  logic [UW-1:0]                 use_words;
  logic [CW-1:0]                 count;
  logic [bsa_pkg::OP_W-1:0]      op_reg;
  logic [bsa_pkg::SLOT_W-1:0]    slot_reg;
  logic [WAW-1:0]                widx;
  logic                          found;
  logic [WAW-1:0]                rd_addr;
  logic [bsa_pkg::WORD_BITS-1:0] rd_data;
  logic                          rd_ok;

  logic [CW-1:0]                 cfg_limit;
  logic [UW-1:0]                 cfg_use_words;
  logic [EFF_WORDS-1:0]          free_vec;
  logic [EFF_WORDS-1:0]          free_low;
  logic [WAW-1:0]                free_idx;
  logic [WAW-1:0]                raddr;
  logic [bsa_pkg::WORD_BITS-1:0] word;
  logic [bsa_pkg::WORD_BITS-1:0] zero_low;
  logic [bsa_pkg::BIT_AW-1:0]    zero_bit;
  logic [CW-1:0]                 entry;
  logic [CW-1:0]                 slot_ext;
  logic                          wr_en;
  logic [bsa_pkg::WORD_BITS-1:0] wdata;
  logic [bsa_pkg::STATUS_W-1:0]  status_next;
  logic [bsa_pkg::SLOT_W-1:0]    granted_next;
  logic [CW-1:0]                 count_next;

  assign stat.out_busy = out_valid && out_stall;

  always_comb begin
    cfg_limit     = (int'(cfg_data) < CAPACITY) ? cfg_data : CW'(CAPACITY);
    cfg_use_words = UW'(({1'b0, cfg_limit} + (CW + 1)'(bsa_pkg::WORD_BITS - 1))
                        >> bsa_pkg::BIT_AW);
  end

  // lowest usable word that still has a free entry
  always_comb begin
    for (int w = 0; w < EFF_WORDS; w++) begin
      free_vec[w] = !full[w] && (w < int'(use_words));
    end
    free_low = free_vec & (~free_vec + EFF_WORDS'(1));
    free_idx = '0;
    for (int w = 0; w < EFF_WORDS; w++) begin
      if (free_low[w]) begin
        free_idx = free_idx | WAW'(w);
      end
    end
  end

  assign raddr = (op_reg == bsa_pkg::OP_FREE) ?
                 WAW'(slot_reg[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_AW]) : widx;

  always_comb begin
    word     = rd_ok ? rd_data : '0;
    zero_low = ~word & (word + bsa_pkg::WORD_BITS'(1));
    zero_bit = '0;
    for (int b = 0; b < bsa_pkg::WORD_BITS; b++) begin
      if (zero_low[b]) begin
        zero_bit = zero_bit | bsa_pkg::BIT_AW'(b);
      end
    end
    entry    = CW'({rd_addr, zero_bit});
    slot_ext = CW'(slot_reg);

    status_next  = bsa_pkg::ST_OK;
    granted_next = '0;
    count_next   = count;
    wr_en        = 1'b0;
    wdata        = word;
    case (op_reg)
      bsa_pkg::OP_ALLOC: begin
        if (found && (entry < limit)) begin
          wr_en        = 1'b1;
          wdata        = word | zero_low;
          granted_next = bsa_pkg::SLOT_W'(entry);
          count_next   = count + CW'(1);
        end else begin
          status_next = bsa_pkg::ST_FULL;
        end
      end
      bsa_pkg::OP_FREE: begin
        if ((slot_ext >= limit) || !word[slot_reg[bsa_pkg::BIT_AW-1:0]]) begin
          status_next = bsa_pkg::ST_BAD;
        end else begin
          wr_en      = 1'b1;
          wdata      = word & ~(bsa_pkg::WORD_BITS'(1) << slot_reg[bsa_pkg::BIT_AW-1:0]);
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[rd_addr] <= wdata;
    end
    if (cmd.read) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg   <= operation;
      slot_reg <= slot_index;
    end
    if (cmd.find) begin
      widx  <= free_idx;
      found <= |free_vec;
    end
    if (cmd.read) begin
      rd_addr <= raddr;
      rd_ok   <= wvalid[raddr];
    end
    if (cmd.commit) begin
      status        <= status_next;
      granted_index <= granted_next;
      in_use        <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid    <= '0;
      full      <= '0;
      count     <= '0;
      limit     <= LIMIT_RST;
      use_words <= USE_WORDS_RST;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        wvalid    <= '0;
        full      <= '0;
        count     <= '0;
        limit     <= cfg_limit;
        use_words <= cfg_use_words;
      end else if (cmd.commit && wr_en) begin
        wvalid[rd_addr] <= 1'b1;
        full[rd_addr]   <= &wdata;
        count           <= count_next;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Watches the request, reply and config channels of the slot allocator,
// keeps its own bitmap of used entries and checks every reply in order.
// ----------------------------------------------------------------------------
module bsa_checker #(
  parameter int NUM_POOLS        = bsa_pkg::NUM_POOLS_DEF,
  parameter int ENTRIES_PER_POOL = bsa_pkg::ENTRIES_PER_POOL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bsa_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bsa_pkg::OP_W-1:0]      operation,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bsa_pkg::STATUS_W-1:0]  status,
  input  logic [bsa_pkg::SLOT_W-1:0]    granted_index,
  input  logic [bsa_pkg::COUNT_W-1:0]   in_use,
  output int                            mismatch_count,
  output int                            replies_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int CAPACITY = NUM_POOLS * ENTRIES_PER_POOL;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted;
    logic [COUNT_W-1:0]  in_use;
  } alloc_reply_t;

  alloc_reply_t       replies_due[$];
  bit                 slot_used[CAPACITY];
  logic [COUNT_W-1:0] used_total;
  int unsigned        usable_limit;
  int                 errors = 0;

  function automatic int unsigned clamp_pool(int unsigned size);
    return (size > CAPACITY) ? CAPACITY : size;
  endfunction

  function automatic void clear_bitmap();
    for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
    used_total = '0;
  endfunction

  // lowest-free-first allocate, checked free, plain count query
  function automatic alloc_reply_t serve_request(logic [OP_W-1:0] op,
                                                 logic [SLOT_W-1:0] slot);
    alloc_reply_t reply;
    int unsigned  hit;
    bit           found;
    reply.status  = ST_OK;
    reply.granted = '0;
    found = 1'b0;
    hit   = 0;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < usable_limit && !found; i++) begin
          if (!slot_used[i]) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (found) begin
          slot_used[hit] = 1'b1;
          used_total     = used_total + COUNT_W'(1);
          reply.granted  = hit[SLOT_W-1:0];
        end else begin
          reply.status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (slot >= usable_limit || !slot_used[slot]) begin
          reply.status = ST_BAD;
        end else begin
          slot_used[slot] = 1'b0;
          used_total      = used_total - COUNT_W'(1);
        end
      end
      default: ;
    endcase
    reply.in_use = used_total;
    return reply;
  endfunction

  task automatic report(string field, int exp_val, int act_val);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    errors++;
  endtask

  always @(posedge clk) begin
    alloc_reply_t exp_reply;
    if (rst) begin
      replies_due.delete();
      clear_bitmap();
      usable_limit = clamp_pool(POOL_SIZE_RESET);
    end else begin
      if (cfg_write) begin
        usable_limit = clamp_pool(32'(cfg_data));
        clear_bitmap();
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply, expected none, %s %0d granted %0d in_use %0d",
                   $time, "actual status", status, granted_index, in_use);
          errors++;
        end else begin
          exp_reply = replies_due.pop_front();
          if (status !== exp_reply.status)
            report("status", int'(exp_reply.status), int'(status));
          if (granted_index !== exp_reply.granted)
            report("granted_index", int'(exp_reply.granted), int'(granted_index));
          if (in_use !== exp_reply.in_use)
            report("in_use", int'(exp_reply.in_use), int'(in_use));
        end
      end
      if (in_valid && !in_stall) replies_due.push_back(serve_request(operation, slot_index));
    end
    replies_pending <= replies_due.size();
    mismatch_count  <= errors;
  end

endmodule

// ----- tb/tb_bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator
// Drives directed and random allocate/free/query traffic over a range of
// pool sizes, with bursty requests and patterned reply stalls.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int CAPACITY     = NUM_POOLS_DEF * ENTRIES_PER_POOL_DEF;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int IDLE_SLACK   = 8;
  localparam int END_SLACK    = 24;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [COUNT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = OP_QUERY;
  logic [SLOT_W-1:0]   slot_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_index;
  logic [COUNT_W-1:0]  in_use;

  int mismatch_count;
  int replies_pending;
  int cycle_count = 0;
  int cur_limit = CAPACITY;

  int          stall_mode = 0;
  logic [7:0]  stall_left = '0;

  bitmap_slot_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_index (granted_index),
    .in_use        (in_use)
  );

  bsa_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .slot_index      (slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .granted_index   (granted_index),
    .in_use          (in_use),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[bitmap_slot_allocator] ERROR");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // reply stall: runs of no stall, light, heavy and periodic stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= int'($urandom_range(0, 3));
      stall_left <= 8'($urandom_range(16, 160));
    end else begin
      stall_left <= stall_left - 8'd1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_left[2];
    endcase
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
    in_valid   <= 1'b1;
    operation  <= op;
    slot_index <= slot;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
    repeat (IDLE_SLACK) @(posedge clk);
  endtask

  task automatic set_pool_size(int size);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= size[COUNT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_limit = (int'(size[COUNT_W-1:0]) > CAPACITY) ? CAPACITY : int'(size[COUNT_W-1:0]);
  endtask

  initial begin
    int               pool_choices[13];
    int               sent;
    int               phase_len;
    int               alloc_pct;
    int               nalloc;
    int               window;
    int               burst_left;
    int               pick;
    int               gap;
    logic [OP_W-1:0]  op;
    logic [SLOT_W-1:0] slot;

    pool_choices = '{1, 2, 3, 31, 32, 33, 63, 64, 65, 96, 100, 4096, 8191};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default size, then one entry, none, and a clamped size
    send_request(OP_QUERY, '0);
    send_request(OP_UNUSED, '1);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd1);
    send_request(OP_FREE, 12'd1);
    send_request(OP_FREE, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    set_pool_size(1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 12'd1);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '0);
    set_pool_size(0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    send_request(OP_QUERY, '0);
    set_pool_size(8191);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '1);
    send_request(OP_QUERY, '1);

    sent = 0;
    burst_left = int'($urandom_range(1, 20));
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) set_pool_size(int'($urandom_range(1, 160)));
      else set_pool_size(pool_choices[$urandom_range(0, 12)]);
      phase_len = int'($urandom_range(40, 140));
      alloc_pct = int'($urandom_range(25, 85));
      nalloc = 0;
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        pick = int'($urandom_range(0, 99));
        slot = SLOT_W'($urandom);
        if (pick < alloc_pct) begin
          op = OP_ALLOC;
          nalloc++;
        end else if (pick < 92) begin
          op = OP_FREE;
          window = (nalloc + 4 < cur_limit) ? nalloc + 4 : cur_limit;
          if (window > 0 && $urandom_range(0, 99) < 85)
            slot = SLOT_W'($urandom_range(0, window - 1));
        end else begin
          op = (pick < 96) ? OP_QUERY : OP_UNUSED;
        end
        send_request(op, slot);
        sent++;
        if ($urandom_range(0, 299) == 0) begin
          drain();
        end else begin
          burst_left--;
          if (burst_left <= 0) begin
            gap = int'($urandom_range(0, 99));
            if (gap < 70) idle_for(int'($urandom_range(0, 3)));
            else if (gap < 95) idle_for(int'($urandom_range(4, 12)));
            else idle_for(int'($urandom_range(20, 40)));
            burst_left = int'($urandom_range(1, 20));
          end
        end
      end
    end

    drain();
    repeat (END_SLACK) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[bitmap_slot_allocator] OK");
    end else begin
      $display("[bitmap_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule
